// ----- hdl/esc_pkg.sv -----
package esc_pkg;

    // Floor count and widths follow the fixed field widths of the ports.
    localparam int NUM_FLOORS  = 4;
    localparam int FLOOR_W     = 2;
    localparam int MASK_W      = NUM_FLOORS;
    localparam int CHAR_W      = 8;
    localparam int TICK_W      = 8;
    localparam int TELE_W      = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_TOP  = 8'h33;

    localparam logic [TICK_W-1:0] DOOR_TICKS_RST  = 8'd200;
    localparam logic [TICK_W-1:0] REV_TICKS_RST   = 8'd50;
    localparam logic [TELE_W-1:0] TELE_PERIOD_RST = 6'd30;

    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TELE_PERIOD = 2'd2;

    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [FLOOR_W-1:0] floor_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_RISE = 3'd1,
        ST_FALL = 3'd2,
        ST_DOOR = 3'd3,
        ST_REV  = 3'd4
    } fsm_state_t;

    typedef enum logic [1:0] {
        MOT_STOP = 2'd0,
        MOT_UP   = 2'd1,
        MOT_DOWN = 2'd2
    } motor_t;

    typedef struct packed {
        logic [TICK_W-1:0] door_ticks;
        logic [TICK_W-1:0] rev_ticks;
        logic [TELE_W-1:0] tele_period;
    } esc_cfg_t;

    typedef struct packed {
        fsm_state_t        fsm;
        mask_t             up;
        mask_t             down;
        logic [TICK_W-1:0] wait_cnt;
        logic [TELE_W-1:0] tele_cnt;
        motor_t            motor;
        floor_t            target;
        mask_t             merged;
    } esc_state_t;

    typedef struct packed {
        motor_t     motor;
        fsm_state_t fsm;
        mask_t      up;
        mask_t      down;
        mask_t      merged;
        floor_t     target;
        logic       strobe;
    } esc_result_t;

endpackage

// ----- hdl/esc_step.sv -----
module esc_step
    import esc_pkg::*;
(
    input  esc_state_t            cur,
    input  esc_cfg_t              cfg,
    input  logic                  request_valid,
    input  logic [CHAR_W-1:0]     origin_char,
    input  logic [CHAR_W-1:0]     dest_char,
    input  floor_t                current_floor,
    output esc_state_t            nxt,
    output esc_result_t           res
);

    floor_t             org;
    floor_t             dst;
    logic               req_ok;
    mask_t              up_req;
    mask_t              down_req;
    mask_t              bit_f;
    mask_t              above_m;
    mask_t              below_m;
    mask_t              any_req;
    logic               call_above;
    logic               call_below;
    logic [TELE_W-1:0]  tele_inc;
    logic [TICK_W-1:0]  wait_inc;

    // Request decode: both digits must be '0'..'3'.
    always_comb
    begin
        req_ok   = request_valid
                   && (origin_char inside {[CHAR_ZERO:CHAR_TOP]})
                   && (dest_char inside {[CHAR_ZERO:CHAR_TOP]});
        org      = FLOOR_W'(origin_char - CHAR_ZERO);
        dst      = FLOOR_W'(dest_char - CHAR_ZERO);
        up_req   = cur.up;
        down_req = cur.down;
        if (req_ok && (org < dst))
        begin
            up_req = cur.up | (mask_t'(1) << org) | (mask_t'(1) << dst);
        end
        else if (req_ok && (org > dst))
        begin
            down_req = cur.down | (mask_t'(1) << org) | (mask_t'(1) << dst);
        end
    end

    assign bit_f      = mask_t'(1) << current_floor;
    assign above_m    = ~((mask_t'(2) << current_floor) - mask_t'(1));
    assign below_m    = bit_f - mask_t'(1);
    assign any_req    = up_req | down_req;
    assign call_above = |(any_req & above_m);
    assign call_below = |(any_req & below_m);
    assign wait_inc   = cur.wait_cnt + TICK_W'(1);
    assign tele_inc   = cur.tele_cnt + TELE_W'(1);

    // Controller: next state, masks, wait timer and motor, then telemetry.
    always_comb
    begin
        nxt.fsm      = cur.fsm;
        nxt.up       = up_req;
        nxt.down     = down_req;
        nxt.wait_cnt = cur.wait_cnt;
        nxt.motor    = cur.motor;
        nxt.target   = req_ok ? dst : cur.target;
        case (cur.fsm)
            ST_RISE:
            begin
                if (((up_req & bit_f) != '0)
                    || (!call_above && ((down_req & bit_f) != '0)))
                begin
                    nxt.up       = up_req & ~bit_f;
                    nxt.down     = down_req & ~bit_f;
                    nxt.motor    = MOT_STOP;
                    nxt.fsm      = ST_DOOR;
                    nxt.wait_cnt = '0;
                end
                else if (!call_above)
                begin
                    nxt.motor = MOT_STOP;
                    nxt.fsm   = ST_IDLE;
                end
            end
            ST_FALL:
            begin
                if (((down_req & bit_f) != '0)
                    || (!call_below && ((up_req & bit_f) != '0)))
                begin
                    nxt.up       = up_req & ~bit_f;
                    nxt.down     = down_req & ~bit_f;
                    nxt.motor    = MOT_STOP;
                    nxt.fsm      = ST_DOOR;
                    nxt.wait_cnt = '0;
                end
                else if (!call_below)
                begin
                    nxt.motor = MOT_STOP;
                    nxt.fsm   = ST_IDLE;
                end
            end
            ST_DOOR:
            begin
                nxt.wait_cnt = wait_inc;
                if (wait_inc >= cfg.door_ticks)
                begin
                    nxt.fsm      = ST_REV;
                    nxt.wait_cnt = '0;
                end
            end
            ST_REV:
            begin
                nxt.wait_cnt = wait_inc;
                if (wait_inc >= cfg.rev_ticks)
                begin
                    nxt.fsm = ST_IDLE;
                end
            end
            default:
            begin
                nxt.fsm = ST_IDLE;
                if ((any_req & bit_f) != '0)
                begin
                    nxt.up       = up_req & ~bit_f;
                    nxt.down     = down_req & ~bit_f;
                    nxt.fsm      = ST_DOOR;
                    nxt.wait_cnt = '0;
                end
                else if (call_above)
                begin
                    nxt.motor = MOT_UP;
                    nxt.fsm   = ST_RISE;
                end
                else if (call_below)
                begin
                    nxt.motor = MOT_DOWN;
                    nxt.fsm   = ST_FALL;
                end
                else if (current_floor != '0)
                begin
                    // post a home call at the ground floor
                    nxt.down = down_req | mask_t'(1);
                end
            end
        endcase

        // Telemetry counter and merged mask snapshot.
        nxt.tele_cnt = tele_inc;
        nxt.merged   = cur.merged;
        if (tele_inc >= cfg.tele_period)
        begin
            nxt.tele_cnt = '0;
            nxt.merged   = nxt.up | nxt.down;
        end
    end

    // Result of this tick.
    always_comb
    begin
        res.motor  = nxt.motor;
        res.fsm    = nxt.fsm;
        res.up     = nxt.up;
        res.down   = nxt.down;
        res.merged = nxt.merged;
        res.target = nxt.target;
        res.strobe = (tele_inc >= cfg.tele_period);
    end

endmodule

// ----- hdl/elevator_scan_controller_core.sv -----
// Channel   Direction  Handshake            Beat carries
// --------  ---------  -------------------  -----------------------------------------------
// in        input      in_valid/in_ready    request_valid, origin_char, dest_char,
//                                           current_floor (one 10 ms tick)
// out       output     out_valid/out_ready  motor_drive, ctrl_state, up_calls, down_calls,
//                                           pending_floors, target_floor, telemetry_strobe
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//
// One tick beat is taken per cycle while in_ready is high; its result is registered in the
// output register, or in the skid while out is stalled. The whole tick update is one pass of
// logic from the state registers into the state and output registers, so the rate is one beat
// per cycle while in_ready is high. A two-entry output buffer (output register plus skid)
// holds results while out is stalled; in_ready drops only when both entries are full.
// Reset puts the controller in idle with empty masks and loads the default timer
// and telemetry settings; cfg_ready is always high.
module elevator_scan_controller_core
    import esc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  request_valid,
    input  logic [CHAR_W-1:0]     origin_char,
    input  logic [CHAR_W-1:0]     dest_char,
    input  logic [FLOOR_W-1:0]    current_floor,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            motor_drive,
    output logic [2:0]            ctrl_state,
    output logic [MASK_W-1:0]     up_calls,
    output logic [MASK_W-1:0]     down_calls,
    output logic [MASK_W-1:0]     pending_floors,
    output logic [FLOOR_W-1:0]    target_floor,
    output logic                  telemetry_strobe,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    esc_cfg_t    cfg_reg;
    esc_cfg_t    cfg_next;
    esc_state_t  st_reg;
    esc_state_t  st_next;
    esc_result_t step_res;

    logic        out_valid_reg;
    logic        out_valid_next;
    esc_result_t out_data_reg;
    esc_result_t out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    esc_result_t skid_data_reg;
    esc_result_t skid_data_next;

    logic        in_beat;
    logic        out_beat;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_beat   = in_valid && in_ready;
    assign out_beat  = out_valid_reg && out_ready;

    // Register writes: an index beyond the list is dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DOOR_TICKS:  cfg_next.door_ticks  = TICK_W'(cfg_data);
                CFG_REV_TICKS:   cfg_next.rev_ticks   = TICK_W'(cfg_data);
                CFG_TELE_PERIOD: cfg_next.tele_period = TELE_W'(cfg_data);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Tick update logic.
    esc_step u_step
    (
        .cur           (st_reg),
        .cfg           (cfg_reg),
        .request_valid (request_valid),
        .origin_char   (origin_char),
        .dest_char     (dest_char),
        .current_floor (current_floor),
        .nxt           (st_next),
        .res           (step_res)
    );

    // Output buffer: fill the output register first, spill to skid while stalled.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_beat)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_beat;
                out_data_next  = step_res;
            end
        end
        else if (in_beat)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = step_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.door_ticks  <= DOOR_TICKS_RST;
            cfg_reg.rev_ticks   <= REV_TICKS_RST;
            cfg_reg.tele_period <= TELE_PERIOD_RST;
            st_reg.fsm          <= ST_IDLE;
            st_reg.up           <= '0;
            st_reg.down         <= '0;
            st_reg.wait_cnt     <= '0;
            st_reg.tele_cnt     <= '0;
            st_reg.motor        <= MOT_STOP;
            st_reg.target       <= '0;
            st_reg.merged       <= '0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            // advance the controller only on an accepted tick beat
            if (in_beat)
            begin
                st_reg <= st_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid        = out_valid_reg;
    assign motor_drive      = out_data_reg.motor;
    assign ctrl_state       = out_data_reg.fsm;
    assign up_calls         = out_data_reg.up;
    assign down_calls       = out_data_reg.down;
    assign pending_floors   = out_data_reg.merged;
    assign target_floor     = out_data_reg.target;
    assign telemetry_strobe = out_data_reg.strobe;

endmodule

// ----- bench/tb_elevator_scan_controller_core.sv -----
module tb_elevator_scan_controller_core;
    import esc_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung.
    // The worst correct case is a full sender gap overlapping a full receiver
    // stall plus the closing pause, far below this.
    localparam int HANG_LIMIT   = 2000;
    // Closing pause once every expected beat is in.
    localparam int SETTLE_TICKS = 16;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_TICKS  = 244;
    localparam int WALK_LEN     = 22;

    // One row of the directed walk. When pinned is set, the typed result is the
    // expectation; otherwise the car model below supplies it.
    typedef struct packed {
        logic        req;
        logic [7:0]  oc;
        logic [7:0]  dc;
        floor_t      fl;
        logic        pinned;
        esc_result_t want;
    } tick_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  request_valid = 1'b0;
    logic [CHAR_W-1:0]     origin_char = '0;
    logic [CHAR_W-1:0]     dest_char = '0;
    logic [FLOOR_W-1:0]    current_floor = '0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            motor_drive;
    logic [2:0]            ctrl_state;
    logic [MASK_W-1:0]     up_calls;
    logic [MASK_W-1:0]     down_calls;
    logic [MASK_W-1:0]     pending_floors;
    logic [FLOOR_W-1:0]    target_floor;
    logic                  telemetry_strobe;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    elevator_scan_controller_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .request_valid    (request_valid),
        .origin_char      (origin_char),
        .dest_char        (dest_char),
        .current_floor    (current_floor),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .motor_drive      (motor_drive),
        .ctrl_state       (ctrl_state),
        .up_calls         (up_calls),
        .down_calls       (down_calls),
        .pending_floors   (pending_floors),
        .target_floor     (target_floor),
        .telemetry_strobe (telemetry_strobe),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Car model: own copy of the controller registers and settings
    // ------------------------------------------------------------------
    logic [TICK_W-1:0] door_cfg = DOOR_TICKS_RST;
    logic [TICK_W-1:0] rev_cfg  = REV_TICKS_RST;
    logic [TELE_W-1:0] tele_cfg = TELE_PERIOD_RST;

    fsm_state_t        car_fsm    = ST_IDLE;
    mask_t             car_up     = '0;
    mask_t             car_down   = '0;
    logic [TICK_W-1:0] car_wait   = '0;
    logic [TELE_W-1:0] car_tele   = '0;
    motor_t            car_motor  = MOT_STOP;
    floor_t            car_target = '0;
    mask_t             car_merged = '0;

    esc_result_t expected_beats[$];
    int          fails = 0;

    // Clear both call masks at the floor, stop and open the door.
    function automatic void open_doors(int unsigned f);
        car_up    &= ~mask_t'(1 << f);
        car_down  &= ~mask_t'(1 << f);
        car_motor  = MOT_STOP;
        car_fsm    = ST_DOOR;
        car_wait   = '0;
    endfunction

    // Advance the car model by one tick and return the result beat it gives.
    function automatic esc_result_t step_controller(logic req, logic [7:0] oc,
                                                    logic [7:0] dc, floor_t fl);
        int unsigned f;
        int unsigned o;
        int unsigned d;
        int unsigned here;
        int unsigned above;
        int unsigned below;
        mask_t       live;
        logic        strobe;
        esc_result_t r;

        f = fl;
        if (f >= NUM_FLOORS)
        begin
            f = NUM_FLOORS - 1;
        end
        here = 1 << f;
        strobe = 1'b0;

        // Take the request only when both bytes are floor digits.
        if (req && oc >= CHAR_ZERO && dc >= CHAR_ZERO)
        begin
            o = oc - CHAR_ZERO;
            d = dc - CHAR_ZERO;
            if (o < NUM_FLOORS && d < NUM_FLOORS)
            begin
                car_target = floor_t'(d);
                if (o < d)
                    car_up |= mask_t'((1 << o) | (1 << d));
                else if (o > d)
                    car_down |= mask_t'((1 << o) | (1 << d));
            end
        end

        live  = car_up | car_down;
        above = ((1 << NUM_FLOORS) - 1) & ~((2 << f) - 1);
        below = (1 << f) - 1;

        case (car_fsm)
            ST_RISE:
            begin
                if ((car_up & here) != 0)
                    open_doors(f);
                else if ((live & above) == 0)
                begin
                    if ((car_down & here) != 0)
                        open_doors(f);
                    else
                    begin
                        car_motor = MOT_STOP;
                        car_fsm   = ST_IDLE;
                    end
                end
            end
            ST_FALL:
            begin
                if ((car_down & here) != 0)
                    open_doors(f);
                else if ((live & below) == 0)
                begin
                    if ((car_up & here) != 0)
                        open_doors(f);
                    else
                    begin
                        car_motor = MOT_STOP;
                        car_fsm   = ST_IDLE;
                    end
                end
            end
            ST_DOOR:
            begin
                car_wait = car_wait + 8'd1;
                if (car_wait >= door_cfg)
                begin
                    car_fsm  = ST_REV;
                    car_wait = '0;
                end
            end
            ST_REV:
            begin
                car_wait = car_wait + 8'd1;
                if (car_wait >= rev_cfg)
                    car_fsm = ST_IDLE;
            end
            default:
            begin
                // Serve a call here first, then head up, then down, else go home.
                car_fsm = ST_IDLE;
                if ((live & here) != 0)
                    open_doors(f);
                else if ((live & above) != 0)
                begin
                    car_motor = MOT_UP;
                    car_fsm   = ST_RISE;
                end
                else if ((live & below) != 0)
                begin
                    car_motor = MOT_DOWN;
                    car_fsm   = ST_FALL;
                end
                else if (f != 0)
                    car_down |= mask_t'(1);
            end
        endcase

        car_tele = car_tele + 6'd1;
        if (car_tele >= tele_cfg)
        begin
            strobe     = 1'b1;
            car_merged = car_up | car_down;
            car_tele   = '0;
        end

        r.motor  = car_motor;
        r.fsm    = car_fsm;
        r.up     = car_up;
        r.down   = car_down;
        r.merged = car_merged;
        r.target = car_target;
        r.strobe = strobe;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts, field-by-field compare
    // ------------------------------------------------------------------
    logic rx_stall_en = 1'b1;
    int   rx_hold = 0;

    always @(posedge clk)
    begin
        if (!rx_stall_en)
            out_ready <= 1'b1;
        else if (rx_hold != 0)
        begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            rx_hold   <= $urandom_range(0, 13);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        esc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: result beat with nothing expected", $time);
                fails++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("motor_drive", want.motor, motor_drive);
                check_field("ctrl_state", want.fsm, ctrl_state);
                check_field("up_calls", want.up, up_calls);
                check_field("down_calls", want.down, down_calls);
                check_field("pending_floors", want.merged, pending_floors);
                check_field("target_floor", want.target, target_floor);
                check_field("telemetry_strobe", want.strobe, telemetry_strobe);
            end
        end
    end

    // Hang detector: count cycles in which no channel moves a beat.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, HANG_LIMIT);
            $display("FAIL elevator_scan_controller_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tick side
    // ------------------------------------------------------------------
    logic tx_gaps_on = 1'b1;

    // Present one tick beat, hold it until taken, then log its expected result.
    // Leave in_valid high afterwards so back-to-back beats never toggle it.
    task automatic send_tick(input logic req, input logic [7:0] oc,
                             input logic [7:0] dc, input floor_t fl,
                             input logic pinned, input esc_result_t typed);
        esc_result_t predicted;
        if (tx_gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        request_valid <= req;
        origin_char   <= oc;
        dest_char     <= dc;
        current_floor <= fl;
        do @(posedge clk); while (!in_ready);
        predicted = step_controller(req, oc, dc, fl);
        expected_beats.push_back(pinned ? typed : predicted);
    endtask

    // Drop valid and hold off until every expected beat has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_beats.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DOOR_TICKS:  door_cfg = data;
            CFG_REV_TICKS:   rev_cfg  = data;
            CFG_TELE_PERIOD: tele_cfg = data[TELE_W-1:0];
            default: ;
        endcase
    endtask

    // Reprogram all three timers; only call with the controller drained.
    task automatic load_settings(input logic [7:0] door, input logic [7:0] rev,
                                 input logic [7:0] tele);
        write_reg(CFG_DOOR_TICKS, door);
        write_reg(CFG_REV_TICKS, rev);
        write_reg(CFG_TELE_PERIOD, tele);
        cfg_valid <= 1'b0;
    endtask

    // Directed walk, run with door 2, settle 1, telemetry every 3 ticks.
    // Pinned rows: first tick out of reset, out-of-range request bytes while
    // away from home (posts the home call), bytes below '0' at home (serves it).
    tick_row_t walk_rows [WALK_LEN] = '{
        '{1'b0, 8'h00, 8'h00, 2'd0, 1'b1,
          '{MOT_STOP, ST_IDLE, 4'h0, 4'h0, 4'h0, 2'd0, 1'b0}},
        '{1'b1, 8'hFF, 8'hFF, 2'd3, 1'b1,
          '{MOT_STOP, ST_IDLE, 4'h0, 4'h1, 4'h0, 2'd0, 1'b0}},
        '{1'b1, 8'h00, 8'h00, 2'd0, 1'b1,
          '{MOT_STOP, ST_DOOR, 4'h0, 4'h0, 4'h0, 2'd0, 1'b1}},
        '{1'b1, "0",   "3",   2'd0, 1'b0, '0},   // up calls at both ends
        '{1'b1, "3",   "0",   2'd0, 1'b0, '0},   // down calls at both ends
        '{1'b1, "2",   "2",   2'd0, 1'b0, '0},   // same floor: target only
        '{1'b1, "4",   "1",   2'd0, 1'b0, '0},   // origin past the top
        '{1'b0, "1",   "2",   2'd0, 1'b0, '0},   // digits without request flag
        '{1'b1, "/",   "1",   2'd0, 1'b0, '0},   // just below '0'
        '{1'b1, "1",   "2",   2'd1, 1'b0, '0},
        '{1'b0, "0",   "0",   2'd1, 1'b0, '0},
        '{1'b0, "0",   "0",   2'd2, 1'b0, '0},
        '{1'b0, "0",   "0",   2'd3, 1'b0, '0},
        '{1'b1, "3",   "1",   2'd3, 1'b0, '0},
        '{1'b0, "0",   "0",   2'd3, 1'b0, '0},
        '{1'b0, "0",   "0",   2'd2, 1'b0, '0},
        '{1'b0, "0",   "0",   2'd1, 1'b0, '0},
        '{1'b0, "0",   "0",   2'd0, 1'b0, '0},
        '{1'b1, "2",   "0",   2'd2, 1'b0, '0},
        '{1'b0, "0",   "0",   2'd1, 1'b0, '0},
        '{1'b1, "0",   "4",   2'd0, 1'b0, '0},   // destination past the top
        '{1'b0, 8'hAA, 8'h55, 2'd3, 1'b0, '0}
    };

    // Timer plans per random phase: all-ones, all-zero and minimum extremes,
    // reset values, and a telemetry write with the unused upper bits set.
    logic [7:0] door_plan [NUM_PHASES] = '{8'd1, 8'd255, 8'd0, 8'd4,
                                           8'd200, 8'd3, 8'd1, 8'd9};
    logic [7:0] rev_plan  [NUM_PHASES] = '{8'd1, 8'd255, 8'd0, 8'd2,
                                           8'd50, 8'd1, 8'd255, 8'd6};
    logic [7:0] tele_plan [NUM_PHASES] = '{8'd1, 8'd63, 8'd0, 8'd5,
                                           8'd30, 8'hC7, 8'd2, 8'd12};

    initial
    begin : stimulus
        int          cab_floor;
        int          cab_dwell;
        int          pick;
        logic        req;
        logic [7:0]  oc;
        logic [7:0]  dc;
        floor_t      fl;

        cab_floor = 0;
        cab_dwell = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(8'd2, 8'd1, 8'd3);
        for (int i = 0; i < WALK_LEN; i++)
            send_tick(walk_rows[i].req, walk_rows[i].oc, walk_rows[i].dc,
                      walk_rows[i].fl, walk_rows[i].pinned, walk_rows[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            load_settings(door_plan[ph], rev_plan[ph], tele_plan[ph]);
            // Run two phases back to back with no idling, the last one included.
            tx_gaps_on   = (ph != 4 && ph != NUM_PHASES - 1);
            rx_stall_en <= (ph != 4 && ph != NUM_PHASES - 1);

            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                // Move the cab one floor every few ticks while the motor runs.
                if (car_motor != MOT_STOP)
                begin
                    if (cab_dwell == 0)
                    begin
                        if (car_motor == MOT_UP && cab_floor < NUM_FLOORS - 1)
                            cab_floor++;
                        else if (car_motor == MOT_DOWN && cab_floor > 0)
                            cab_floor--;
                        cab_dwell = $urandom_range(0, 2);
                    end
                    else
                        cab_dwell--;
                end

                // Mostly the true position; now and then a glitchy sensor.
                if ($urandom_range(0, 9) == 0)
                    fl = floor_t'($urandom_range(0, NUM_FLOORS - 1));
                else
                    fl = floor_t'(cab_floor);

                req  = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    oc = CHAR_ZERO + 8'($urandom_range(0, NUM_FLOORS - 1));
                    dc = CHAR_ZERO + 8'($urandom_range(0, NUM_FLOORS - 1));
                end
                else if (pick == 8)
                begin
                    oc = 8'($urandom_range(0, 255));
                    dc = 8'($urandom_range(0, 255));
                end
                else
                begin
                    // Bytes just around the digit range.
                    oc = CHAR_ZERO - 8'd2 + 8'($urandom_range(0, 7));
                    dc = CHAR_ZERO - 8'd2 + 8'($urandom_range(0, 7));
                end

                send_tick(req, oc, dc, fl, 1'b0, '0);

                // Now and then let the result side empty completely mid-phase.
                if (tx_gaps_on && $urandom_range(0, 119) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);

        if (fails == 0)
            $display("PASS elevator_scan_controller_core");
        else
            $display("FAIL elevator_scan_controller_core");
        $finish;
    end

endmodule
